[design/evg_pkg.sv]
package evg_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int REM_W        = CNT_W + 1;
    localparam int PHASE_W      = 32;
    localparam int DIV_STAGES   = 4;
    localparam int DIV_BITS     = PHASE_W / DIV_STAGES;
    localparam int VEC_W        = 33;
    localparam int COORD_W      = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_COUNT   = 3'd2,
        REG_OUTLINE = 3'd3
    } cfg_reg_t;

    // control that travels with each word down the pipe
    typedef struct packed {
        logic valid;
        logic err;
    } pipe_ctl_t;

    // arctangent of 2^-i in units of 2^-32 turn, truncated
    function automatic logic [PHASE_W-1:0] atan_turn(input int i);
        logic [PHASE_W-1:0] a;
        case (i)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2F9;
            15:      a = 32'h0000_517C;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A2F;
            19:      a = 32'h0000_0517;
            20:      a = 32'h0000_028B;
            21:      a = 32'h0000_0145;
            22:      a = 32'h0000_00A2;
            23:      a = 32'h0000_0051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[design/evg_divider.sv]
module evg_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  evg_pkg::pipe_ctl_t         ctl_in,
    input  logic [evg_pkg::IDX_W-1:0]  idx,
    input  logic [evg_pkg::CNT_W-1:0]  divisor,
    output evg_pkg::pipe_ctl_t         ctl_out,
    output logic [evg_pkg::PHASE_W-1:0] phase
);
    import evg_pkg::*;

    pipe_ctl_t           ctl_reg [DIV_STAGES];
    logic [REM_W-1:0]    rem_reg [DIV_STAGES];
    logic [PHASE_W-1:0]  quo_reg [DIV_STAGES];

    // restoring long division of idx * 2^32, a few quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        pipe_ctl_t          ctl_prev;
        logic [REM_W-1:0]   rem_prev;
        logic [PHASE_W-1:0] quo_prev;
        logic [REM_W-1:0]   rem_next;
        logic [DIV_BITS-1:0] bits_next;

        if (s == 0) begin : g_first
            assign ctl_prev = ctl_in;
            // closing index of an outline equals the divisor; the whole turn wraps away
            assign rem_prev = (REM_W'(idx) >= REM_W'(divisor))
                              ? REM_W'(idx) - REM_W'(divisor)
                              : REM_W'(idx);
            assign quo_prev = '0;
        end
        else begin : g_rest
            assign ctl_prev = ctl_reg[s-1];
            assign rem_prev = rem_reg[s-1];
            assign quo_prev = quo_reg[s-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] r;
            r = rem_prev;
            bits_next = '0;
            for (int b = 0; b < DIV_BITS; b++)
            begin
                r = {r[REM_W-2:0], 1'b0};
                if (r >= REM_W'(divisor))
                begin
                    r = r - REM_W'(divisor);
                    bits_next[DIV_BITS-1-b] = 1'b1;
                end
            end
            rem_next = r;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (en)
            begin
                ctl_reg[s] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= {quo_prev[PHASE_W-DIV_BITS-1:0], bits_next};
            end
        end
    end

    assign ctl_out = ctl_reg[DIV_STAGES-1];
    assign phase   = quo_reg[DIV_STAGES-1];

`ifndef SYNTHESIS
    // remainder stays below the divisor on every live word
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_out.valid && !ctl_out.err) |-> (rem_reg[DIV_STAGES-1] < REM_W'(divisor)))
        else $error("divider remainder out of range");
`endif

endmodule

[design/evg_cordic.sv]
module evg_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  evg_pkg::pipe_ctl_t                ctl_in,
    input  logic [evg_pkg::PHASE_W-1:0]       phase,
    output evg_pkg::pipe_ctl_t                ctl_out,
    output logic [1:0]                        quad,
    output logic signed [evg_pkg::VEC_W-1:0]  vec_x,
    output logic signed [evg_pkg::VEC_W-1:0]  vec_y
);
    import evg_pkg::*;

    pipe_ctl_t                  ctl_reg  [CORDIC_STEPS];
    logic [1:0]                 quad_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0]    x_reg    [CORDIC_STEPS];
    logic signed [VEC_W-1:0]    y_reg    [CORDIC_STEPS];
    logic signed [PHASE_W-1:0]  z_reg    [CORDIC_STEPS];

    // nearest quarter turn, residual within one eighth of a turn
    logic [PHASE_W-1:0] phase_rounded;
    logic [1:0]         quad_in;
    logic [PHASE_W-1:0] z_in;

    assign phase_rounded = phase + 32'h2000_0000;
    assign quad_in       = phase_rounded[PHASE_W-1:PHASE_W-2];
    assign z_in          = phase - {quad_in, {(PHASE_W-2){1'b0}}};

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        pipe_ctl_t                 ctl_prev;
        logic [1:0]                quad_prev;
        logic signed [VEC_W-1:0]   x_prev;
        logic signed [VEC_W-1:0]   y_prev;
        logic signed [PHASE_W-1:0] z_prev;
        logic signed [VEC_W-1:0]   x_next;
        logic signed [VEC_W-1:0]   y_next;
        logic signed [PHASE_W-1:0] z_next;

        if (i == 0) begin : g_first
            assign ctl_prev  = ctl_in;
            assign quad_prev = quad_in;
            assign x_prev    = CORDIC_GAIN;
            assign y_prev    = '0;
            assign z_prev    = $signed(z_in);
        end
        else begin : g_rest
            assign ctl_prev  = ctl_reg[i-1];
            assign quad_prev = quad_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign z_prev    = z_reg[i-1];
        end

        always_comb
        begin
            if (z_prev[PHASE_W-1])
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + $signed(atan_turn(i));
            end
            else
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - $signed(atan_turn(i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else if (en)
            begin
                ctl_reg[i] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[i] <= quad_prev;
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
            end
        end
    end

    assign ctl_out = ctl_reg[CORDIC_STEPS-1];
    assign quad    = quad_reg[CORDIC_STEPS-1];
    assign vec_x   = x_reg[CORDIC_STEPS-1];
    assign vec_y   = y_reg[CORDIC_STEPS-1];

endmodule

[design/ellipse_vertex_generator.sv]
// channel   direction  handshake               word
// input     in         in_valid / in_ready     vertex_index
// output    out        out_valid / out_ready   point_x, point_y, index_error
// config    in         cfg_write (no wait)     cfg_index, cfg_data
//
// one vertex accepted per cycle unless stalled: 4 divider stages
// (8 phase bits each), 16 cordic stages (one rotation each), quadrant and
// q1.15 rounding, multiply, final rounding into the output register
// reset clears valid bits and config registers (count 36, fan mode)
// a stall freezes the whole pipe; in_ready = !out_valid || out_ready
module ellipse_vertex_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_write,
    input  logic [evg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [evg_pkg::CFG_W-1:0]          cfg_data,
    // vertex index word in
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [evg_pkg::IDX_W-1:0]          vertex_index,
    // point word out
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [evg_pkg::COORD_W-1:0] point_x,
    output logic signed [evg_pkg::COORD_W-1:0] point_y,
    output logic                               index_error
);
    import evg_pkg::*;

    // config registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CNT_W-1:0] count_reg;
    logic             outline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= '0;
            height_reg  <= '0;
            count_reg   <= CNT_W'(36);
            outline_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:   width_reg   <= cfg_data;
                REG_HEIGHT:  height_reg  <= cfg_data;
                REG_COUNT:   count_reg   <= cfg_data[CNT_W-1:0];
                REG_OUTLINE: outline_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // effective count and divisor; outline mode drops one so the strip closes
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] divisor;

    assign count_eff = (count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_reg;
    assign divisor   = (outline_reg && count_eff > CNT_W'(1)) ? count_eff - CNT_W'(1)
                                                              : count_eff;

    // pipe advances whenever the output register is free or being drained
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    pipe_ctl_t ctl_in;
    assign ctl_in.valid = in_valid;
    assign ctl_in.err   = CNT_W'(vertex_index) >= count_eff;

    // phase = idx * 2^32 / d
    pipe_ctl_t          div_ctl;
    logic [PHASE_W-1:0] div_phase;

    evg_divider u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (ctl_in),
        .idx     (vertex_index),
        .divisor (divisor),
        .ctl_out (div_ctl),
        .phase   (div_phase)
    );

    pipe_ctl_t               cor_ctl;
    logic [1:0]              cor_quad;
    logic signed [VEC_W-1:0] cor_x;
    logic signed [VEC_W-1:0] cor_y;

    evg_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (div_ctl),
        .phase   (div_phase),
        .ctl_out (cor_ctl),
        .quad    (cor_quad),
        .vec_x   (cor_x),
        .vec_y   (cor_y)
    );

    // quadrant rotation, then round to q1.15 with saturation
    localparam int RND_W = VEC_W + 1;

    function automatic logic signed [COORD_W-1:0] to_q15(input logic signed [VEC_W-1:0] v);
        logic signed [RND_W-1:0] t;
        logic signed [RND_W-1:0] r;
        logic signed [COORD_W-1:0] q;
        t = RND_W'(v) + RND_W'(1 << 14);
        r = t >>> 15;
        if (r > RND_W'(32767))
            q = 16'sh7FFF;
        else if (r < -RND_W'(32768))
            q = 16'sh8000;
        else
            q = r[COORD_W-1:0];
        return q;
    endfunction

    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;

    always_comb
    begin
        case (cor_quad)
            2'd0:
            begin
                rot_x = cor_x;
                rot_y = cor_y;
            end
            2'd1:
            begin
                rot_x = -cor_y;
                rot_y = cor_x;
            end
            2'd2:
            begin
                rot_x = -cor_x;
                rot_y = -cor_y;
            end
            default:
            begin
                rot_x = cor_y;
                rot_y = -cor_x;
            end
        endcase
    end

    pipe_ctl_t                 trig_ctl_reg;
    logic signed [COORD_W-1:0] cos_reg;
    logic signed [COORD_W-1:0] sin_reg;

    // half-axis products, q12.4 full size times q1.15
    localparam int PROD_W = 2 * COORD_W + 1;

    pipe_ctl_t                 prod_ctl_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;

    assign prod_x_next = $signed({1'b0, width_reg})  * cos_reg;
    assign prod_y_next = $signed({1'b0, height_reg}) * sin_reg;

    // final rounding: (p + 2^15) >>> 16, low 16 bits
    logic signed [PROD_W:0]    sum_x;
    logic signed [PROD_W:0]    sum_y;
    logic signed [COORD_W-1:0] pt_x_next;
    logic signed [COORD_W-1:0] pt_y_next;

    assign sum_x     = (PROD_W+1)'(prod_x_reg) + (PROD_W+1)'(1 << 15);
    assign sum_y     = (PROD_W+1)'(prod_y_reg) + (PROD_W+1)'(1 << 15);
    assign pt_x_next = prod_ctl_reg.err ? '0 : sum_x[2*COORD_W-1:COORD_W];
    assign pt_y_next = prod_ctl_reg.err ? '0 : sum_y[2*COORD_W-1:COORD_W];

    logic                      out_valid_reg;
    logic                      err_reg;
    logic signed [COORD_W-1:0] pt_x_reg;
    logic signed [COORD_W-1:0] pt_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ctl_reg  <= '0;
            prod_ctl_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            trig_ctl_reg  <= cor_ctl;
            prod_ctl_reg  <= trig_ctl_reg;
            out_valid_reg <= prod_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg    <= to_q15(rot_x);
            sin_reg    <= to_q15(rot_y);
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            err_reg    <= prod_ctl_reg.err;
            pt_x_reg   <= pt_x_next;
            pt_y_reg   <= pt_y_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign index_error = err_reg;
    assign point_x     = pt_x_reg;
    assign point_y     = pt_y_reg;

`ifndef SYNTHESIS
    // an out-of-range vertex always comes out at the origin
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && index_error) |-> (point_x == '0 && point_y == '0))
        else $error("error word with nonzero coordinates");

    // input is held off exactly while a finished word waits
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // a frozen pipe keeps its output word
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> (out_valid && $stable(point_x) && $stable(point_y)))
        else $error("output word changed during stall");
`endif

endmodule

[test/tb_ellipse_vertex_generator.sv]
`timescale 1ns / 1ps

// checks the ellipse vertex generator against an in-bench fixed point
// predictor: a directed table first, then random vertex streams under
// several register settings and idling patterns
module tb_ellipse_vertex_generator;
    import evg_pkg::*;

    // expected point word
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      err;
    } point_t;

    // one row of the directed table: register setting, index, and an optional
    // typed expectation (otherwise the predictor supplies it)
    typedef struct {
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] cnt;
        logic        outl;
        logic [9:0]  idx;
        bit          typed;
        int          ex;
        int          ey;
        bit          ee;
    } row_t;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_SET   = 72;

    // arctangent of 2^-i in 2^-32 turn units, truncated
    localparam longint ATAN_TURN [24] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [IDX_W-1:0]          vertex_index = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      index_error;

    // register copies used for prediction
    logic [15:0] width_q12  = 16'd0;
    logic [15:0] height_q12 = 16'd0;
    logic [10:0] count_reg  = 11'd36;
    logic        outline_on = 1'b0;

    point_t pending_points[$];
    int     fail_count = 0;
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    int     quiet_cycles = 0;

    ellipse_vertex_generator i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .index_error  (index_error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // round a 30 fraction bit value to q1.15 with saturation
    function automatic longint round_q15(longint v);
        longint r;
        r = (v + (longint'(1) << 14)) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    // expected point for one vertex index under the current registers
    function automatic point_t ellipse_point(logic [9:0] idx);
        point_t p;
        longint unsigned cnt, d, phase, q;
        longint z, vx, vy, nx, ny, cx, cy, c, s;
        cnt = count_reg;
        if (cnt > MAX_VERTICES)
            cnt = MAX_VERTICES;
        p.x = '0;
        p.y = '0;
        p.err = 1'b0;
        if (idx >= cnt)
        begin
            p.err = 1'b1;
            return p;
        end
        d = (outline_on && cnt > 1) ? cnt - 1 : cnt;
        // angle as a fraction of a full turn; closing point wraps to zero
        phase = ((longint'(idx) << 32) / d) & 64'hFFFF_FFFF;
        q = ((phase + 64'h2000_0000) >> 30) & 3;
        z = longint'((phase - (q << 30)) & 64'hFFFF_FFFF);
        if (z >= (longint'(1) << 31))
            z = z - (longint'(1) << 32);
        vx = 652032874;
        vy = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z  = z - ATAN_TURN[i];
            end
            else
            begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z  = z + ATAN_TURN[i];
            end
            vx = nx;
            vy = ny;
        end
        // exact quarter turn rotation
        case (q)
            0: begin cx = vx;  cy = vy;  end
            1: begin cx = -vy; cy = vx;  end
            2: begin cx = -vx; cy = -vy; end
            default: begin cx = vy; cy = -vx; end
        endcase
        c = round_q15(cx);
        s = round_q15(cy);
        p.x = COORD_W'((longint'(width_q12) * c + (longint'(1) << 15)) >>> 16);
        p.y = COORD_W'((longint'(height_q12) * s + (longint'(1) << 15)) >>> 16);
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // output side: random stalls, checking and watchdog
    always @(posedge clk)
    begin
        point_t want;
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else if (out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x)
                    report_mismatch("point_x", point_x, want.x);
                if (point_y !== want.y)
                    report_mismatch("point_y", point_y, want.y);
                if (index_error !== want.err)
                    report_mismatch("index_error", index_error, want.err);
            end
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // full register setting, plus a write to an unused index that must do nothing
    task automatic set_registers(logic [15:0] w, logic [15:0] h, logic [15:0] cnt,
                                 logic outl);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_COUNT, cnt);
        write_reg(REG_OUTLINE, {15'd0, outl});
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_W'($urandom_range(4, 7));
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_write  <= 1'b0;
        width_q12  <= w;
        height_q12 <= h;
        count_reg  <= cnt[10:0];
        outline_on <= outl;
        @(posedge clk);
    endtask

    // wait for every expected word, then let the pipe settle
    task automatic drain();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // offer one vertex index, with random idle cycles before it
    task automatic send_vertex(logic [9:0] idx, bit typed, point_t typed_point);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        vertex_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        pending_points.push_back(typed ? typed_point : ellipse_point(idx));
    endtask

    row_t directed_rows[] = '{
        // reset setting: zero size, 36 vertices, fan
        '{16'h0000, 16'h0000, 16'd36,   1'b0, 10'd0,    1, 0, 0, 0},
        '{16'h0000, 16'h0000, 16'd36,   1'b0, 10'd35,   1, 0, 0, 0},
        '{16'h0000, 16'h0000, 16'd36,   1'b0, 10'd36,   1, 0, 0, 1},
        '{16'h0000, 16'h0000, 16'd36,   1'b0, 10'd1023, 1, 0, 0, 1},
        // count above the maximum saturates, outline closes on the first point
        '{16'hFFFF, 16'hFFFF, 16'd2047, 1'b1, 10'd0,    0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd2047, 1'b1, 10'd1,    0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd2047, 1'b1, 10'd511,  0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd2047, 1'b1, 10'd1022, 0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd2047, 1'b1, 10'd1023, 0, 0, 0, 0},
        // quarter turns at full size
        '{16'hFFFF, 16'hFFFF, 16'd1024, 1'b0, 10'd256,  0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd1024, 1'b0, 10'd512,  0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd1024, 1'b0, 10'd768,  0, 0, 0, 0},
        // zero count flags everything
        '{16'hFFFF, 16'h0000, 16'd0,    1'b0, 10'd0,    1, 0, 0, 1},
        '{16'hFFFF, 16'h0000, 16'd0,    1'b0, 10'd1023, 1, 0, 0, 1},
        // single vertex outline uses a divisor of one
        '{16'h8000, 16'h7FFF, 16'd1,    1'b1, 10'd0,    0, 0, 0, 0},
        '{16'h8000, 16'h7FFF, 16'd1,    1'b1, 10'd1,    1, 0, 0, 1},
        // two vertices, fan
        '{16'h1234, 16'h4321, 16'd2,    1'b0, 10'd0,    0, 0, 0, 0},
        '{16'h1234, 16'h4321, 16'd2,    1'b0, 10'd1,    0, 0, 0, 0},
        '{16'h1234, 16'h4321, 16'd2,    1'b0, 10'd2,    1, 0, 0, 1},
        // smallest outline strip
        '{16'hFFFF, 16'hFFFF, 16'd3,    1'b1, 10'd0,    0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd3,    1'b1, 10'd1,    0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd3,    1'b1, 10'd2,    0, 0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'd3,    1'b1, 10'd3,    1, 0, 0, 1}
    };

    initial
    begin
        row_t        r;
        point_t      tp;
        logic [15:0] w, h, cnt;
        logic        outl;
        int          eff;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first rows run on the reset setting
        w = 16'd0;
        h = 16'd0;
        cnt = 16'd36;
        outl = 1'b0;
        foreach (directed_rows[k])
        begin
            r = directed_rows[k];
            if (r.w != w || r.h != h || r.cnt != cnt || r.outl != outl)
            begin
                in_valid <= 1'b0;
                drain();
                w = r.w;
                h = r.h;
                cnt = r.cnt;
                outl = r.outl;
                set_registers(w, h, cnt, outl);
            end
            tp.x = COORD_W'(r.ex);
            tp.y = COORD_W'(r.ey);
            tp.err = r.ee;
            send_vertex(r.idx, r.typed, tp);
        end

        // random part: four idling patterns, four register settings each
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            for (int s = 0; s < 4; s++)
            begin
                in_valid <= 1'b0;
                drain();
                case (s)
                    0: begin w = 16'hFFFF; h = 16'hFFFF; cnt = 16'd1024; end
                    1: begin w = 16'($urandom); h = 16'($urandom);
                             cnt = 16'($urandom_range(3, 1024)); end
                    2: begin w = ($urandom_range(1)) ? 16'd0 : 16'($urandom);
                             h = 16'($urandom); cnt = 16'($urandom_range(3, 12)); end
                    default: begin w = 16'($urandom); h = 16'($urandom);
                                   cnt = 16'($urandom); end
                endcase
                outl = 1'($urandom_range(1));
                set_registers(w, h, cnt, outl);
                eff = (cnt[10:0] > MAX_VERTICES) ? MAX_VERTICES : cnt[10:0];
                for (int n = 0; n < ITEMS_PER_SET; n++)
                begin
                    // hold off once until the pipe has emptied
                    if (mode == 3 && s == 1 && n == ITEMS_PER_SET / 2)
                    begin
                        in_valid <= 1'b0;
                        @(posedge clk);
                        while (pending_points.size() != 0)
                            @(posedge clk);
                    end
                    if (eff > 0 && $urandom_range(99) < 85)
                        send_vertex(10'($urandom_range(0, eff - 1)), 0, tp);
                    else
                        send_vertex(10'($urandom_range(0, 1023)), 0, tp);
                end
            end
        end

        in_valid <= 1'b0;
        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
design/evg_pkg.sv
design/evg_divider.sv
design/evg_cordic.sv
design/ellipse_vertex_generator.sv
test/tb_ellipse_vertex_generator.sv
